### hdl/elg_pkg.sv
// Shared types and codes for the edge list graph engine.
`timescale 1ns / 1ps

package elg_pkg;

   localparam int VERTEX_W = 7;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int DEGREE_W = 11;
   localparam int EDGE_W   = 2 * VERTEX_W;
   localparam int REQ_W    = 24;
   localparam int RSP_W    = 24;
   localparam int CSR_W    = 8;

   localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_ADD_EDGE   = 3'd0;
   localparam logic [OP_W-1:0] OP_DEGREE     = 3'd1;
   localparam logic [OP_W-1:0] OP_ADJACENT   = 3'd2;
   localparam logic [OP_W-1:0] OP_NEIGHBOURS = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_FINISH
   } state_type;

endpackage

### hdl/edge_list_graph_engine_top.sv
// Top level of the edge list graph engine: edge store, scan sequencer and result register.
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  req       in         req_tvalid/req_tready  req_tdata: operation, vertex_a, vertex_b
//  rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: status, degree_count,
//                                              is_adjacent, neighbour_id; rsp_tlast: last
//  csr       in         csr_tvalid/csr_tready  csr_tdata: vertex_count
//
// Add edge, clear and unknown codes go from idle straight to the finish state. Degree
// and adjacent scan every stored edge; neighbours scans every stored edge and then
// walks vertex ids in ascending order, up to MAX_VERTICES, emitting each neighbour.
// The single read port of the edge store, one edge per cycle, sets the scan length.
// Reset empties the store and sets vertex_count to 64. A stalled result holds the
// engine until it is taken; a new request is accepted while the last result of the
// previous one still waits.

module edge_list_graph_engine_top
   import elg_pkg::*;
#(
   parameter int EDGE_CAPACITY = 512,
   parameter int MAX_VERTICES  = 64
) (
   input  logic             clock,
   input  logic             reset,
   // bits 2:0 operation, 9:3 vertex_a, 16:10 vertex_b, rest zero
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // bits 1:0 status, 12:2 degree_count, 13 is_adjacent, 20:14 neighbour_id, rest zero
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // bits 6:0 vertex_count, bit 7 unused
   input  logic [CSR_W-1:0] csr_tdata,
   input  logic             csr_tvalid,
   output logic             csr_tready
);

   localparam int TOT_W  = $clog2(EDGE_CAPACITY + 1);
   localparam int ADDR_W = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
   localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

   logic [EDGE_W-1:0] edge_mem [EDGE_CAPACITY];
   logic [EDGE_W-1:0] rd_q_ff;

   state_type              state_ff, state_in;
   logic [VERTEX_W-1:0]    vcount_ff, vcount_in;
   logic [TOT_W-1:0]       total_ff, total_in;
   logic [TOT_W-1:0]       iss_ff, iss_in;
   logic                   rdv_ff, rdv_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [VERTEX_W-1:0]    qa_ff, qa_in;
   logic [VERTEX_W-1:0]    qb_ff, qb_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [DEGREE_W-1:0]    count_ff, count_in;
   logic                   hit_ff, hit_in;
   logic [MAX_VERTICES-1:0] mask_ff, mask_in;
   logic [VIDX_W-1:0]      walk_ff, walk_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [OP_W-1:0]        req_op;
   logic [VERTEX_W-1:0]    req_a;
   logic [VERTEX_W-1:0]    req_b;
   logic [VERTEX_W-1:0]    lim;
   logic                   req_fire;
   logic                   slot_free;
   logic                   add_ok;
   logic                   endpoints_ok;
   logic                   store_full;
   logic [VERTEX_W-1:0]    end_x;
   logic [VERTEX_W-1:0]    end_y;
   logic                   scan_done;
   logic [MAX_VERTICES-1:0] rest;
   logic                   walk_hit;

   assign req_op = req_tdata[OP_W-1:0];
   assign req_a  = req_tdata[OP_W +: VERTEX_W];
   assign req_b  = req_tdata[OP_W+VERTEX_W +: VERTEX_W];

   assign lim = (vcount_ff > VERTEX_W'(MAX_VERTICES)) ? VERTEX_W'(MAX_VERTICES) : vcount_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_tready = 1'b1;
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign endpoints_ok = (req_a >= VERTEX_W'(1)) && (req_b >= VERTEX_W'(1))
                         && (req_a <= lim) && (req_b <= lim);
   assign store_full   = (total_ff == TOT_W'(EDGE_CAPACITY));
   assign add_ok       = req_fire && (req_op == OP_ADD_EDGE) && endpoints_ok && !store_full;

   assign end_x = rd_q_ff[VERTEX_W-1:0];
   assign end_y = rd_q_ff[EDGE_W-1:VERTEX_W];

   assign scan_done = (iss_ff == total_ff) && !rdv_ff;
   assign walk_hit  = mask_ff[walk_ff];

   // Bits above the one being emitted; the walk clears bits as it passes them.
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         rest[i] = mask_ff[i] && (VIDX_W'(i) != walk_ff);
      end
   end

   // Edge store: one write port for add edge, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (add_ok) begin
         edge_mem[total_ff[ADDR_W-1:0]] <= {req_b, req_a};
      end
      rd_q_ff <= edge_mem[iss_ff[ADDR_W-1:0]];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_DEGREE || req_op == OP_ADJACENT
                   || req_op == OP_NEIGHBOURS) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               if (op_ff == OP_NEIGHBOURS && mask_ff != '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_EMIT: begin
            if (walk_hit && slot_free && rest == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result register.
   always_comb begin
      vcount_in    = vcount_ff;
      total_in     = total_ff;
      iss_in       = iss_ff;
      rdv_in       = 1'b0;
      op_in        = op_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      hit_in       = hit_ff;
      mask_in      = mask_ff;
      walk_in      = walk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_tvalid && csr_tready) begin
         vcount_in = csr_tdata[VERTEX_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_op;
               qa_in     = req_a;
               qb_in     = req_b;
               status_in = STATUS_OK;
               count_in  = '0;
               hit_in    = 1'b0;
               mask_in   = '0;
               walk_in   = '0;
               iss_in    = '0;
               if (req_op == OP_ADD_EDGE) begin
                  if (!endpoints_ok) begin
                     status_in = STATUS_INVALID;
                  end else if (store_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     total_in = total_ff + TOT_W'(1);
                  end
               end else if (req_op == OP_CLEAR) begin
                  total_in = '0;
               end
            end
         end
         ST_SCAN: begin
            if (iss_ff != total_ff) begin
               iss_in = iss_ff + TOT_W'(1);
               rdv_in = 1'b1;
            end
            if (rdv_ff) begin
               count_in = count_ff + DEGREE_W'(end_x == qa_ff) + DEGREE_W'(end_y == qa_ff);
               if ((end_x == qa_ff && end_y == qb_ff) || (end_x == qb_ff && end_y == qa_ff)) begin
                  hit_in = 1'b1;
               end
               for (int i = 0; i < MAX_VERTICES; i++) begin
                  if ((end_x == qa_ff && end_y == VERTEX_W'(i + 1) && end_y <= lim)
                      || (end_y == qa_ff && end_x == VERTEX_W'(i + 1) && end_x <= lim)) begin
                     mask_in[i] = 1'b1;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (walk_hit) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_data_in[STATUS_W+DEGREE_W]       = 1'b1;
                  rsp_data_in[STATUS_W+DEGREE_W+1 +: VERTEX_W] =
                     VERTEX_W'(walk_ff) + VERTEX_W'(1);
                  rsp_last_in  = (rest == '0);
                  mask_in      = rest;
                  walk_in      = walk_ff + VIDX_W'(1);
               end
            end else begin
               walk_in = walk_ff + VIDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[STATUS_W-1:0] = status_ff;
               if (op_ff == OP_DEGREE) begin
                  rsp_data_in[STATUS_W +: DEGREE_W] = count_ff;
               end
               if (op_ff == OP_ADJACENT) begin
                  rsp_data_in[STATUS_W+DEGREE_W] = hit_ff;
               end
               rsp_last_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= VERTEX_COUNT_RESET;
         total_ff     <= '0;
         iss_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         total_ff     <= total_in;
         iss_ff       <= iss_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      qa_ff       <= qa_in;
      qb_ff       <= qb_in;
      status_ff   <= status_in;
      count_ff    <= count_in;
      hit_ff      <= hit_in;
      mask_ff     <= mask_in;
      walk_ff     <= walk_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### tb/edge_list_graph_engine_top_test.sv
// Self-checking testbench for the edge list graph engine, with a queue-fed driver and a predictor.
`timescale 1ns / 1ps

module edge_list_graph_engine_top_test;
   import elg_pkg::*;

   localparam int CAPACITY = 512;
   localparam int MAX_IDS  = 64;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [VERTEX_W-1:0] va;
      logic [VERTEX_W-1:0] vb;
   } graph_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DEGREE_W-1:0] degree;
      logic                adjacent;
      logic [VERTEX_W-1:0] neighbour;
      logic                last;
   } graph_answer_type;

   logic             clock;
   logic             reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [CSR_W-1:0] csr_tdata = '0;
   logic             csr_tvalid = 1'b0;
   logic             csr_tready;

   // Predictor state: the stored edges, their number and the vertex count register.
   logic [EDGE_W-1:0]   edge_list [0:CAPACITY-1];
   int                  edges_held = 0;
   logic [VERTEX_W-1:0] vertex_limit = VERTEX_COUNT_RESET;

   graph_request_type pending_requests[$];
   graph_answer_type  graph_answers[$];
   int             mismatch_count = 0;
   int             answers_seen = 0;
   logic           req_taken = 1'b0;
   logic           allow_idle = 1'b1;
   int             sender_gap = 0;
   int             receiver_stall = 0;

   edge_list_graph_engine_top #(
      .EDGE_CAPACITY(CAPACITY),
      .MAX_VERTICES (MAX_IDS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_tdata (csr_tdata),
      .csr_tvalid(csr_tvalid),
      .csr_tready(csr_tready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on result %0d (%s): got %0d, expected %0d at %0t ns",
               answers_seen, what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic int live_limit();
      return (vertex_limit > MAX_IDS) ? MAX_IDS : int'(vertex_limit);
   endfunction

   // Works out the answers of one accepted request and updates the edge list.
   task automatic apply_graph_op(logic [OP_W-1:0] op, logic [VERTEX_W-1:0] va,
                                 logic [VERTEX_W-1:0] vb);
      graph_answer_type ans;
      int            lim;
      int            qa;
      int            qb;
      int            x;
      int            y;
      int            tally;
      logic [63:0]   mask;
      lim = live_limit();
      qa = int'(va);
      qb = int'(vb);
      ans = '0;
      ans.last = 1'b1;
      case (op)
         OP_ADD_EDGE: begin
            if (qa < 1 || qb < 1 || qa > lim || qb > lim) begin
               ans.status = STATUS_INVALID;
            end else if (edges_held >= CAPACITY) begin
               ans.status = STATUS_FULL;
            end else begin
               edge_list[edges_held] = {vb, va};
               edges_held++;
               ans.status = STATUS_OK;
            end
            graph_answers.push_back(ans);
         end
         OP_DEGREE: begin
            tally = 0;
            for (int k = 0; k < edges_held; k++) begin
               if (edge_list[k][VERTEX_W-1:0] == va) tally++;
               if (edge_list[k][EDGE_W-1:VERTEX_W] == va) tally++;
            end
            ans.degree = DEGREE_W'(tally);
            graph_answers.push_back(ans);
         end
         OP_ADJACENT: begin
            for (int k = 0; k < edges_held; k++) begin
               x = int'(edge_list[k][VERTEX_W-1:0]);
               y = int'(edge_list[k][EDGE_W-1:VERTEX_W]);
               if ((x == qa && y == qb) || (x == qb && y == qa)) ans.adjacent = 1'b1;
            end
            graph_answers.push_back(ans);
         end
         OP_NEIGHBOURS: begin
            mask = '0;
            for (int k = 0; k < edges_held; k++) begin
               x = int'(edge_list[k][VERTEX_W-1:0]);
               y = int'(edge_list[k][EDGE_W-1:VERTEX_W]);
               if (x == qa && y >= 1 && y <= lim) mask[y-1] = 1'b1;
               if (y == qa && x >= 1 && x <= lim) mask[x-1] = 1'b1;
            end
            if (mask == '0) begin
               graph_answers.push_back(ans);
            end else begin
               for (int id = 1; id <= lim; id++) begin
                  if (mask[id-1]) begin
                     ans.adjacent = 1'b1;
                     ans.neighbour = VERTEX_W'(id);
                     ans.last = ((mask >> id) == '0);
                     graph_answers.push_back(ans);
                  end
               end
            end
         end
         OP_CLEAR: begin
            edges_held = 0;
            graph_answers.push_back(ans);
         end
         default: begin
            graph_answers.push_back(ans);
         end
      endcase
   endtask

   task automatic check_answer();
      graph_answer_type want;
      answers_seen++;
      if (graph_answers.size() == 0) begin
         report_mismatch("result with nothing pending", int'(rsp_tdata), 0);
         return;
      end
      want = graph_answers.pop_front();
      if (rsp_tdata[1:0] != want.status)
         report_mismatch("status", int'(rsp_tdata[1:0]), int'(want.status));
      if (rsp_tdata[12:2] != want.degree)
         report_mismatch("degree_count", int'(rsp_tdata[12:2]), int'(want.degree));
      if (rsp_tdata[13] != want.adjacent)
         report_mismatch("is_adjacent", int'(rsp_tdata[13]), int'(want.adjacent));
      if (rsp_tdata[20:14] != want.neighbour)
         report_mismatch("neighbour_id", int'(rsp_tdata[20:14]), int'(want.neighbour));
      if (rsp_tlast != want.last)
         report_mismatch("last", int'(rsp_tlast), int'(want.last));
   endtask

   // Request driver: holds an item until its transfer, then may idle for a burst.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         sender_gap = 0;
      end else if (req_tvalid && !req_taken) begin
         // Item still waiting for its transfer.
      end else begin
         req_taken = 1'b0;
         if (sender_gap > 0) begin
            sender_gap--;
            req_tvalid <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            sender_gap = int'($urandom_range(0, 3));
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            graph_request_type item;
            item = pending_requests.pop_front();
            req_tdata <= {{(REQ_W - OP_W - 2 * VERTEX_W){1'b0}}, item.vb, item.va, item.op};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: mostly ready, with random stall bursts while idling is allowed.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (receiver_stall > 0) begin
         receiver_stall--;
         rsp_tready <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 4) == 0) begin
         receiver_stall = int'($urandom_range(0, 3));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on each request transfer and checks each result transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            apply_graph_op(req_tdata[OP_W-1:0], req_tdata[OP_W+VERTEX_W-1:OP_W],
                           req_tdata[OP_W+2*VERTEX_W-1:OP_W+VERTEX_W]);
         end
         if (rsp_tvalid && rsp_tready) check_answer();
      end
   end

   task automatic queue_op(logic [OP_W-1:0] op, int va, int vb);
      graph_request_type item;
      item.op = op;
      item.va = VERTEX_W'(va);
      item.vb = VERTEX_W'(vb);
      pending_requests.push_back(item);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || graph_answers.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_vertex_count(int value);
      wait_drained();
      @(negedge clock);
      csr_tdata <= {1'b0, value[VERTEX_W-1:0]};
      csr_tvalid <= 1'b1;
      do @(posedge clock); while (!csr_tready);
      vertex_limit = value[VERTEX_W-1:0];
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // Mostly ids from the low vertices up to 8 so that edges meet, with some out-of-range ids.
   function automatic int pick_vertex();
      int lim;
      int r;
      lim = live_limit();
      r = int'($urandom_range(0, 19));
      if (lim == 0 || r == 0) return int'($urandom_range(0, 127));
      if (r == 1) return 0;
      if (r == 2) return 127;
      if (r < 12) return int'($urandom_range(1, (lim < 8) ? lim : 8));
      return int'($urandom_range(1, lim));
   endfunction

   task automatic run_random_block(int count);
      int r;
      logic [OP_W-1:0] op;
      for (int n = 0; n < count; n++) begin
         r = int'($urandom_range(0, 99));
         if (r < 35)      op = OP_ADD_EDGE;
         else if (r < 50) op = OP_DEGREE;
         else if (r < 65) op = OP_ADJACENT;
         else if (r < 86) op = OP_NEIGHBOURS;
         else if (r < 89) op = OP_CLEAR;
         else if (r < 94) op = OP_W'($urandom_range(OP_CLEAR + 1, 2 ** OP_W - 1));
         else             op = OP_W'($urandom_range(0, 2 ** OP_W - 1));
         queue_op(op, pick_vertex(), pick_vertex());
      end
   endtask

   initial begin
      int hub;
      int counts[7];
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_vertex_count(64);

      // Directed part: empty graph, edge cases of add, every query and unused codes.
      queue_op(OP_NEIGHBOURS, 5, 0);
      queue_op(OP_DEGREE, 5, 0);
      queue_op(OP_ADD_EDGE, 1, 64);
      queue_op(OP_ADD_EDGE, 64, 64);
      queue_op(OP_ADD_EDGE, 0, 3);
      queue_op(OP_ADD_EDGE, 3, 0);
      queue_op(OP_ADD_EDGE, 65, 2);
      queue_op(OP_ADD_EDGE, 127, 127);
      queue_op(OP_ADD_EDGE, 5, 1);
      queue_op(OP_ADD_EDGE, 5, 64);
      queue_op(OP_DEGREE, 64, 127);
      queue_op(OP_DEGREE, 127, 0);
      queue_op(OP_DEGREE, 0, 0);
      queue_op(OP_ADJACENT, 64, 1);
      queue_op(OP_ADJACENT, 1, 64);
      queue_op(OP_ADJACENT, 2, 3);
      queue_op(OP_ADJACENT, 127, 0);
      queue_op(OP_NEIGHBOURS, 64, 0);
      queue_op(OP_NEIGHBOURS, 1, 127);
      queue_op(OP_NEIGHBOURS, 127, 0);
      queue_op(OP_W'(OP_CLEAR + 1), 127, 127);
      queue_op(OP_W'(2 ** OP_W - 1), 0, 0);
      queue_op(OP_CLEAR, 0, 0);
      queue_op(OP_NEIGHBOURS, 64, 0);

      // Edges with high ids, then a shrunk count: neighbours must drop them.
      set_vertex_count(64);
      queue_op(OP_ADD_EDGE, 3, 40);
      queue_op(OP_ADD_EDGE, 50, 3);
      queue_op(OP_ADD_EDGE, 3, 7);
      set_vertex_count(10);
      queue_op(OP_NEIGHBOURS, 3, 0);
      queue_op(OP_DEGREE, 3, 0);
      queue_op(OP_ADJACENT, 40, 3);
      queue_op(OP_NEIGHBOURS, 50, 0);

      // Fill the store with self-loops on one vertex: top degree, then a full store.
      set_vertex_count(64);
      queue_op(OP_CLEAR, 0, 0);
      for (int i = 0; i < CAPACITY; i++) queue_op(OP_ADD_EDGE, 64, 64);
      queue_op(OP_DEGREE, 64, 0);
      queue_op(OP_ADD_EDGE, 1, 2);
      queue_op(OP_ADD_EDGE, 0, 2);
      queue_op(OP_NEIGHBOURS, 64, 0);
      queue_op(OP_ADJACENT, 64, 64);
      queue_op(OP_CLEAR, 0, 0);

      // A vertex joined to every vertex gives the longest neighbour list.
      wait_drained();
      hub = int'($urandom_range(1, MAX_IDS));
      for (int id = MAX_IDS; id >= 1; id--) begin
         if ($urandom_range(0, 1)) queue_op(OP_ADD_EDGE, hub, id);
         else queue_op(OP_ADD_EDGE, id, hub);
      end
      queue_op(OP_NEIGHBOURS, hub, 0);
      queue_op(OP_ADD_EDGE, 1, 1);
      for (int i = 0; i < 6; i++) begin
         queue_op(OP_NEIGHBOURS, int'($urandom_range(1, MAX_IDS)), 0);
         queue_op(OP_DEGREE, int'($urandom_range(1, MAX_IDS)), 0);
         queue_op(OP_ADJACENT, int'($urandom_range(1, MAX_IDS)),
                  int'($urandom_range(1, MAX_IDS)));
      end
      queue_op(OP_CLEAR, 0, 0);

      // Random part across several vertex counts; the last block runs without idling.
      counts = '{1, 127, 0, 64, 10, 100, 64};
      for (int blk = 0; blk < 7; blk++) begin
         set_vertex_count((blk == 6) ? int'($urandom_range(1, 127)) : counts[blk]);
         if (blk == 6) allow_idle = 1'b0;
         run_random_block(20);
      end

      wait_drained();
      repeat (700) @(posedge clock);
      if (mismatch_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

### edge_list_graph_engine_top.f
hdl/elg_pkg.sv
hdl/edge_list_graph_engine_top.sv
tb/edge_list_graph_engine_top_test.sv
